// ===== design/greedy_box_nms_defines.svh =====
// ----------------------------------------------------------------------------
// greedy_box_nms_defines
// assertion macros shared by the greedy box nms modules
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_NMS_DEFINES_SVH
`define GREEDY_BOX_NMS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define GBNMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbnms assertion failed");
// next-cycle implication
`define GBNMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbnms assertion failed");
`else
`define GBNMS_ASSERT_NOW(label, ante, cons)
`define GBNMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/gbnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gbnms_pkg
// types and constants for the greedy box non-maximum suppression block
// ----------------------------------------------------------------------------
package gbnms_pkg;

	localparam int MAX_KEPT_DEF   = 64;
	localparam int COORD_BITS_DEF = 16;

	localparam logic [15:0] THRESHOLD_RESET = 16'd29491;

	// register map, byte address bit 2 selects the register
	localparam int          ADDR_W         = 3;
	localparam logic        REG_THRESHOLD  = 1'b0;

	typedef struct packed {
		logic        first_of_set;
		logic [15:0] left_edge;
		logic [15:0] top_edge;
		logic [15:0] right_edge;
		logic [15:0] bottom_edge;
	} box_word_t;

	typedef struct packed {
		logic        kept;
		logic [15:0] item_index;
		logic [5:0]  kept_slot;
		logic        status;
	} result_word_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} dp_stat_t;

endpackage

// ===== design/greedy_box_nms.sv =====
// ----------------------------------------------------------------------------
// greedy_box_nms
// greedy non-maximum suppression over score-sorted boxes, iou threshold q0.16
// ----------------------------------------------------------------------------
// channel   signals                                  transfer
// box       start, busy, box                         start & !busy
// result    done, result                             done, one cycle
// config    psel, penable, pwrite, paddr, pwdata,    access phase, pready = 1
//           prdata, pready
//
// a box is compared with every kept box of its set, one kept box a cycle
// through a five-stage compare pipe fed by the table memory read port.
// the result strobe follows once the last compare has left the pipe, and
// busy falls in the same cycle.
// reset empties the table and the item counter; the threshold returns to 0.45.
// the result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
	parameter int MAX_KEPT   = gbnms_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gbnms_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  gbnms_pkg::box_word_t          box,
	output logic                          done,
	output gbnms_pkg::result_word_t       result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gbnms_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import gbnms_pkg::*;

	logic [15:0] threshold_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'b0, threshold_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
			threshold_q <= pwdata[15:0];
		end
	end

	gbnms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	gbnms_dp #(
		.MAX_KEPT   (MAX_KEPT),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.box       (box),
		.threshold (threshold_q),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== design/gbnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbnms_ctrl
// sequencer: load a box, walk the kept table, drain the compare pipe, commit
// ----------------------------------------------------------------------------
module gbnms_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gbnms_pkg::dp_stat_t stat,
	output logic              busy,
	output gbnms_pkg::dp_cmd_t  cmd
);
	import gbnms_pkg::*;
	`include "greedy_box_nms_defines.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.issue  = (state_q == ST_SCAN) && !stat.scan_done;
		cmd.commit = (state_q == ST_DRAIN) && !stat.pipe_busy;
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`GBNMS_ASSERT_NEXT(a_issue_fills_pipe, cmd.issue, stat.pipe_busy)
	`GBNMS_ASSERT_NOW(a_idle_pipe_empty, !busy, !stat.pipe_busy)
	`GBNMS_ASSERT_NEXT(a_load_clean_start, cmd.load, busy && !stat.pipe_busy)

endmodule

// ===== design/gbnms_dp.sv =====
// ----------------------------------------------------------------------------
// gbnms_dp
// kept-box memory, counters and the five-stage overlap compare pipe
// ----------------------------------------------------------------------------
module gbnms_dp #(
	parameter int MAX_KEPT   = gbnms_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gbnms_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gbnms_pkg::dp_cmd_t      cmd,
	input  gbnms_pkg::box_word_t    box,
	input  logic [15:0]             threshold,
	output gbnms_pkg::dp_stat_t     stat,
	output logic                    done,
	output gbnms_pkg::result_word_t result
);
	import gbnms_pkg::*;
	`include "greedy_box_nms_defines.svh"

	localparam int CB  = COORD_BITS;
	localparam int KCW = $clog2(MAX_KEPT + 1);
	localparam int AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int AR  = 2 * CB;
	localparam int UW  = AR + 1;
	localparam int PW  = AR + 17;

	function automatic logic [CB-1:0] clip(input logic [15:0] v);
		logic [CB+15:0] e;
		e = {{CB{1'b0}}, v};
		return e[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] span(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

	// current box
	logic [CB-1:0] cx0_q, cy0_q, cx1_q, cy1_q;
	logic [AR-1:0] cur_area_q;

	// counters and table
	logic [KCW-1:0] kept_cnt_q;
	logic [KCW-1:0] rd_idx_q;
	logic [15:0]    item_cnt_q;
	logic [15:0]    idx_q;
	logic           hit_q;
	logic [4*CB-1:0] mem [MAX_KEPT];

	// pipe
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [4*CB-1:0] box_s1;
	logic [CB-1:0]   ix_s2, iy_s2, bw_s2, bh_s2;
	logic [AR-1:0]   inter_s3, barea_s3;
	logic [AR-1:0]   inter_s4;
	logic [UW-1:0]   uni_s4;
	logic [PW-1:0]   lhs_s5, rhs_s5;
	logic            nz_s5;

	logic [CB-1:0] bx0, by0, bx1, by1;
	logic [CB-1:0] il, ir, it, ib;
	logic          room;
	logic          wr_en;
	logic [KCW+5:0] slot_ext;

	assign bx0 = box_s1[4*CB-1:3*CB];
	assign by0 = box_s1[3*CB-1:2*CB];
	assign bx1 = box_s1[2*CB-1:CB];
	assign by1 = box_s1[CB-1:0];

	assign il = (cx0_q > bx0) ? cx0_q : bx0;
	assign ir = (cx1_q < bx1) ? cx1_q : bx1;
	assign it = (cy0_q > by0) ? cy0_q : by0;
	assign ib = (cy1_q < by1) ? cy1_q : by1;

	assign room     = kept_cnt_q < KCW'(MAX_KEPT);
	assign wr_en    = cmd.commit && !hit_q && room;
	assign slot_ext = {6'b0, kept_cnt_q};

	assign stat.scan_done = (rd_idx_q == kept_cnt_q);
	assign stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[kept_cnt_q[AW-1:0]] <= {cx0_q, cy0_q, cx1_q, cy1_q};
		end
		if (cmd.issue) begin
			box_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx0_q <= clip(box.left_edge);
			cy0_q <= clip(box.top_edge);
			cx1_q <= clip(box.right_edge);
			cy1_q <= clip(box.bottom_edge);
		end
		cur_area_q <= AR'(span(cx0_q, cx1_q)) * AR'(span(cy0_q, cy1_q));
		ix_s2      <= span(il, ir);
		iy_s2      <= span(it, ib);
		bw_s2      <= span(bx0, bx1);
		bh_s2      <= span(by0, by1);
		inter_s3   <= AR'(ix_s2) * AR'(iy_s2);
		barea_s3   <= AR'(bw_s2) * AR'(bh_s2);
		uni_s4     <= {1'b0, cur_area_q} + {1'b0, barea_s3} - {1'b0, inter_s3};
		inter_s4   <= inter_s3;
		lhs_s5     <= {1'b0, inter_s4, 16'b0};
		rhs_s5     <= PW'(uni_s4) * PW'(threshold);
		nz_s5      <= (uni_s4 != '0);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_cnt_q <= '0;
			rd_idx_q   <= '0;
			item_cnt_q <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			done       <= 1'b0;
			result     <= '0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= cmd.commit;

			if (cmd.load) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				if (box.first_of_set) begin
					kept_cnt_q <= '0;
					idx_q      <= '0;
					item_cnt_q <= 16'd1;
				end else begin
					idx_q <= item_cnt_q;
					if (item_cnt_q != 16'hFFFF) begin
						item_cnt_q <= item_cnt_q + 16'd1;
					end
				end
			end

			if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + KCW'(1);
			end

			if (v_s5 && nz_s5 && (lhs_s5 > rhs_s5)) begin
				hit_q <= 1'b1;
			end

			if (cmd.commit) begin
				result.kept       <= !hit_q;
				result.item_index <= idx_q;
				result.kept_slot  <= wr_en ? slot_ext[5:0] : 6'd0;
				result.status     <= !hit_q && !room;
				if (wr_en) begin
					kept_cnt_q <= kept_cnt_q + KCW'(1);
				end
			end
		end
	end

	`GBNMS_ASSERT_NOW(a_scan_in_range, 1'b1, rd_idx_q <= kept_cnt_q)
	`GBNMS_ASSERT_NOW(a_count_bound, 1'b1, kept_cnt_q <= KCW'(MAX_KEPT))
	`GBNMS_ASSERT_NEXT(a_done_single, done, !done)
	`GBNMS_ASSERT_NOW(a_full_report, done && result.status,
		result.kept && (kept_cnt_q == KCW'(MAX_KEPT)))

endmodule
